// ===== rtl/core/arp_responder_and_cache_assert.svh =====
// Assertion macros shared by the ARP responder and cache RTL.
// Include by bare file name; the enclosing module supplies i_clk and i_rst_n.
`ifndef ARP_RESPONDER_AND_CACHE_ASSERT_SVH
`define ARP_RESPONDER_AND_CACHE_ASSERT_SVH

// generic clocked check with explicit clock and active-low reset
`define ARPC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on the house clock and reset
`define ARPC_ASSERT(lbl, prop, msg) \
    `ARPC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/arpc_pkg.sv =====
// Package for the ARP responder and cache: header constants, action codes and
// the search token handed along the cell chain. No dependencies.
package arpc_pkg;

    localparam logic [15:0] HW_ETHERNET  = 16'h0100;
    localparam logic [15:0] PROTO_IPV4   = 16'h0008;
    localparam logic [15:0] OP_REQUEST   = 16'h0100;
    localparam logic [15:0] OP_RESPONSE  = 16'h0200;
    localparam logic [15:0] OP_NONE      = 16'h0000;
    localparam logic [7:0]  HW_ADDR_LEN  = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN  = 8'd4;
    localparam logic [15:0] MSG_BYTES    = 16'd28;
    localparam logic [47:0] MAC_ALL_ONES = 48'hffff_ffff_ffff;

    localparam logic KIND_MESSAGE = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    typedef enum logic [2:0] {
        ACT_IGNORED    = 3'd0,
        ACT_SEND_REPLY = 3'd1,
        ACT_LEARNED    = 3'd2,
        ACT_LEARN_FULL = 3'd3,
        ACT_LOOKUP_HIT = 3'd4,
        ACT_SEND_REQ   = 3'd5
    } t_action;

    // lookup token moving one cell per cycle
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [47:0] mac;
    } t_token;

endpackage

// ===== rtl/core/arpc_cell.sv =====
// One cache entry of the ARP cache chain: holds an IP/MAC pair and passes the
// lookup token to its neighbor. Depends on arpc_pkg.
module arpc_cell
    import arpc_pkg::*;
#(
    parameter int CNT_W = 8,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_wr,
    input  logic [31:0]      i_wr_ip,
    input  logic [47:0]      i_wr_mac,
    input  logic [31:0]      i_query_ip,
    input  t_token           i_tok,
    output t_token           o_tok
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [31:0] r_ip;
    logic [47:0] r_mac;
    t_token      r_tok;
    t_token      n_tok;
    logic        w_match;

    // entry is live once the fill count has passed it
    assign w_match = (MY_IDX < i_count) && (r_ip == i_query_ip);

    always_ff @(posedge i_clk) begin
        if (i_wr && (i_count == MY_IDX)) begin
            r_ip  <= i_wr_ip;
            r_mac <= i_wr_mac;
        end
    end

    always_comb begin
        n_tok       = i_tok;
        n_tok.valid = i_tok.valid;
        if (i_tok.valid && !i_tok.hit && w_match) begin
            n_tok.hit = 1'b1;
            n_tok.mac = r_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.hit <= n_tok.hit;
        r_tok.mac <= n_tok.mac;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/arp_responder_and_cache.sv =====
// Top level of the ARP responder and cache: message checks, cache fill and the
// lookup walk over a chain of arpc_cell entries. Depends on arpc_pkg, arpc_cell
// and arp_responder_and_cache_assert.svh.
//
//  channel   dir  handshake                    payload
//  s_axis    in   i_s_tvalid / o_s_tready      tdata 192b message, tuser kind
//  m_axis    out  o_m_tvalid / i_m_tready      tdata 96b result, tuser action
//  cfg       in   i_cfg_valid / o_cfg_ready    index 1b, data 48b
//
// A received message has its result registered in r_res and then moved to the output register;
// a lookup first walks its token through the cell chain one entry per cycle, then does the same.
// One item is in work at a time; the next is taken once the result sits in the
// output register, even while that result waits on i_m_tready.
// Reset empties the cache (fill count to zero) and clears own_ip; no clearing pass.
// Configuration is always ready; own_mac writes are taken but drive no output.
module arp_responder_and_cache
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [15:0] payload_length, [31:16] hw_type, [47:32] proto_type,
    // [55:48] hw_addr_len, [63:56] proto_addr_len, [79:64] opcode,
    // [111:80] sender_ip, [159:112] sender_mac, [191:160] target_ip
    input  logic [191:0] i_s_tdata,
    // [0] kind
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [15:0] out_opcode, [47:16] out_dst_ip, [95:48] out_mac
    output logic [95:0]  o_m_tdata,
    // [2:0] action
    output logic [2:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] opcode;
        logic [31:0] dst_ip;
        logic [47:0] mac;
    } t_result;

    // input fields
    logic        w_kind;
    logic [15:0] w_plen, w_hwt, w_prt, w_op;
    logic [7:0]  w_hwl, w_prl;
    logic [31:0] w_sip, w_tip;
    logic [47:0] w_smac;

    assign w_kind = i_s_tuser[0];
    assign w_plen = i_s_tdata[15:0];
    assign w_hwt  = i_s_tdata[31:16];
    assign w_prt  = i_s_tdata[47:32];
    assign w_hwl  = i_s_tdata[55:48];
    assign w_prl  = i_s_tdata[63:56];
    assign w_op   = i_s_tdata[79:64];
    assign w_sip  = i_s_tdata[111:80];
    assign w_smac = i_s_tdata[159:112];
    assign w_tip  = i_s_tdata[191:160];

    t_state           r_state, n_state;
    logic [31:0]      r_own_ip;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_query;
    logic             r_start;
    t_result          r_res, n_res;
    logic             r_out_valid;
    t_result          r_out;

    logic    w_accept;
    logic    w_hdr_ok;
    logic    w_learn;
    logic    w_out_free;
    t_token  w_tok [0:CACHE_ENTRIES];

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign w_hdr_ok = (w_plen >= MSG_BYTES) && (w_hwt == HW_ETHERNET) &&
                      (w_prt == PROTO_IPV4) && (w_hwl == HW_ADDR_LEN) &&
                      (w_prl == IP_ADDR_LEN) && (w_tip == r_own_ip);

    assign w_learn = w_accept && (w_kind == KIND_MESSAGE) && w_hdr_ok &&
                     (w_op == OP_RESPONSE) && (r_count < CNT_FULL);

    // cell chain, token enters in the cycle after the lookup request is accepted
    assign w_tok[0] = '{valid: r_start, hit: 1'b0, mac: MAC_ALL_ONES};

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .CNT_W (CNT_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_wr       (w_learn),
            .i_wr_ip    (w_sip),
            .i_wr_mac   (w_smac),
            .i_query_ip (r_query),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_kind == KIND_LOOKUP) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                        n_res   = '{action: ACT_IGNORED, opcode: OP_NONE,
                                    dst_ip: 32'd0, mac: MAC_ALL_ONES};
                        if (w_hdr_ok && (w_op == OP_REQUEST)) begin
                            n_res = '{action: ACT_SEND_REPLY, opcode: OP_RESPONSE,
                                      dst_ip: w_sip, mac: w_smac};
                        end else if (w_hdr_ok && (w_op == OP_RESPONSE)) begin
                            n_res.action = (r_count < CNT_FULL) ? ACT_LEARNED
                                                                : ACT_LEARN_FULL;
                        end
                    end
                end
            end
            S_WALK: begin
                if (w_tok[CACHE_ENTRIES].valid) begin
                    n_state = S_DONE;
                    // a cached all-ones MAC counts as a miss
                    if (w_tok[CACHE_ENTRIES].hit &&
                        (w_tok[CACHE_ENTRIES].mac != MAC_ALL_ONES)) begin
                        n_res = '{action: ACT_LOOKUP_HIT, opcode: OP_NONE,
                                  dst_ip: r_query, mac: w_tok[CACHE_ENTRIES].mac};
                    end else begin
                        n_res = '{action: ACT_SEND_REQ, opcode: OP_REQUEST,
                                  dst_ip: r_query, mac: MAC_ALL_ONES};
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_own_ip    <= 32'd0;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && (w_kind == KIND_LOOKUP);
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_OWN_IP)) begin
                r_own_ip <= i_cfg_data[31:0];
            end
            if (w_learn) begin
                r_count <= r_count + CNT_W'(1);
            end
            // hand the finished result to the output register, or drain it
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_query <= w_tip;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.action;
    assign o_m_tdata  = {r_out.mac, r_out.dst_ip, r_out.opcode};

`include "arp_responder_and_cache_assert.svh"

    `ARPC_ASSERT(a_accept_leaves_idle, w_accept |=> (r_state != S_IDLE), "request accepted but block stayed idle")
    `ARPC_ASSERT(a_token_only_in_walk, w_tok[CACHE_ENTRIES].valid |-> (r_state == S_WALK), "lookup token left chain outside walk")
    `ARPC_ASSERT(a_count_bounded, r_count <= CNT_FULL, "cache fill count beyond capacity")
    `ARPC_ASSERT(a_learn_advances, w_learn |=> (r_count == $past(r_count) + CNT_W'(1)), "learned entry did not advance fill count")

endmodule
